/* hw/rtl/ats_pkg.sv */
`default_nettype none

package ats_pkg;

  // largest register index accepted is REGISTER_COUNT - 1
  localparam int REGISTER_COUNT = 32;

  // result queue: one byte can cause up to three tokens
  localparam int MAX_RUN = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int LINE_W  = 24;
  localparam int COL_W   = 16;
  localparam int VALUE_W = 64;
  localparam int LEN_W   = 8;
  localparam int CFG_W   = 24;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  // configuration register indexes
  localparam logic CFG_START_LINE   = 1'b0;
  localparam logic CFG_START_COLUMN = 1'b1;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_O  = 8'h6f;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  // packed keyword text, first byte in the low bits
  localparam logic [VALUE_W-1:0] MOV_PACKED = 64'h0000_0000_0076_6f6d;
  localparam logic [VALUE_W-1:0] RET_PACKED = 64'h0000_0000_0074_6572;
  localparam logic [VALUE_W-1:0] KW_MOV = 64'd0;
  localparam logic [VALUE_W-1:0] KW_RET = 64'd1;

  typedef enum logic [2:0] {
    TK_EOF     = 3'd0,
    TK_NUMBER  = 3'd1,
    TK_REG     = 3'd2,
    TK_KEYWORD = 3'd3,
    TK_IDENT   = 3'd4,
    TK_COLON   = 3'd5,
    TK_COMMA   = 3'd6,
    TK_UNKNOWN = 3'd7
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_PEND    = 3'd2,
    MODE_NUM     = 3'd3,
    MODE_WORD    = 3'd4
  } scan_mode_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  typedef struct packed {
    token_kind_t         kind;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    column;
    logic [VALUE_W-1:0]  value;
    logic [LEN_W-1:0]    length;
    logic                last;
  } tok_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  // digit value, 16 when the byte is no hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    if (is_digit(c)) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = 5'(c - 8'h57);
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = 5'(c - 8'h37);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

  function automatic logic [4:0] radix_base(radix_t r);
    logic [4:0] b;
    unique case (r)
      RADIX_DEC: b = 5'd10;
      RADIX_BIN: b = 5'd2;
      RADIX_OCT: b = 5'd8;
      default:   b = 5'd16;
    endcase
    return b;
  endfunction

  function automatic tok_t make_simple(token_kind_t k, logic [LINE_W-1:0] ln,
                                       logic [COL_W-1:0] col);
    tok_t t;
    t = '0;
    t.kind   = k;
    t.line   = ln;
    t.column = col;
    return t;
  endfunction

  function automatic tok_t make_number(logic good, logic seen, logic [VALUE_W-1:0] acc,
                                       logic [LINE_W-1:0] ln, logic [COL_W-1:0] col);
    tok_t t;
    t = '0;
    t.line   = ln;
    t.column = col;
    if (good && seen) begin
      t.kind  = TK_NUMBER;
      t.value = acc;
    end else begin
      t.kind  = TK_UNKNOWN;
      t.value = '1;
    end
    return t;
  endfunction

  function automatic tok_t make_word(logic rgood, logic [7:0] ridx, logic [LEN_W-1:0] len,
                                     logic [VALUE_W-1:0] bytes, logic [LINE_W-1:0] ln,
                                     logic [COL_W-1:0] col);
    tok_t t;
    t = '0;
    t.line   = ln;
    t.column = col;
    if (rgood && (len >= LEN_W'(2))) begin
      t.kind  = TK_REG;
      t.value = {56'd0, ridx};
    end else if ((len == LEN_W'(3)) && (bytes == MOV_PACKED)) begin
      t.kind   = TK_KEYWORD;
      t.value  = KW_MOV;
      t.length = LEN_W'(3);
    end else if ((len == LEN_W'(3)) && (bytes == RET_PACKED)) begin
      t.kind   = TK_KEYWORD;
      t.value  = KW_RET;
      t.length = LEN_W'(3);
    end else begin
      t.kind   = TK_IDENT;
      t.value  = bytes;
      t.length = len;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/assembly_token_scanner.sv */
// Assembly token scanner.
// Input channel: one source byte per request (char_code, is_last) on in_valid /
// in_stall. Output channel: one token per request (token_kind, token_line,
// token_column, token_value, text_length, last_of_run) on out_valid / out_stall.
// A byte may cause zero to three tokens; last_of_run marks the final token of
// the byte that caused it. The byte after is_last begins new content.
// An accepted byte waits in the input register until the queue has room, is
// scanned into the queue, and its tokens leave one per cycle unless out_stall.
// Throughput: one byte per cycle. Bytes are scanned in one pass through the
// input register; tokens wait in a four-entry queue, and a byte is scanned
// only while the queue has room for three tokens, so bytes causing several
// tokens hold the input while the queue drains.
// Stall: out_stall holds the head token steady; the queue fills and in_stall
// rises. Reset (rst, synchronous) empties the queue and the input register,
// sets start_line to 1 and start_column to 0 and returns the scanner to the
// state between tokens. cfg_we writes start_line (index 0) or start_column
// (index 1) from cfg_data; a write applies from the first byte of the next
// content.
`default_nettype none

module assembly_token_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ats_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  char_code,
  input  wire logic                        is_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       token_kind,
  output logic [ats_pkg::LINE_W-1:0]       token_line,
  output logic [ats_pkg::COL_W-1:0]        token_column,
  output logic [ats_pkg::VALUE_W-1:0]      token_value,
  output logic [ats_pkg::LEN_W-1:0]        text_length,
  output logic                             last_of_run
);

  // configuration
  logic [ats_pkg::LINE_W-1:0] start_line;
  logic [ats_pkg::COL_W-1:0]  start_column;

  // input register
  logic       s_valid;
  logic [7:0] s_char;
  logic       s_last;

  // scanner state
  ats_pkg::scan_mode_t          mode, mode_next;
  ats_pkg::radix_t              radix, radix_next;
  logic                         skip, skip_next;
  logic [ats_pkg::VALUE_W-1:0]  accum, accum_next;
  logic                         good, good_next;
  logic                         seen, seen_next;
  logic [ats_pkg::VALUE_W-1:0]  wbytes, wbytes_next;
  logic [ats_pkg::LEN_W-1:0]    wlen, wlen_next;
  logic [7:0]                   ridx, ridx_next;
  logic                         rgood, rgood_next;
  logic [ats_pkg::LINE_W-1:0]   line_cnt, line_cnt_next;
  logic [ats_pkg::COL_W-1:0]    col_cnt, col_cnt_next;
  logic                         first, first_next;
  logic [ats_pkg::LINE_W-1:0]   bline, bline_next;
  logic [ats_pkg::COL_W-1:0]    bcol, bcol_next;

  // result queue
  ats_pkg::tok_t               q [ats_pkg::QDEPTH];
  logic [ats_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [ats_pkg::QCNT_W-1:0]  q_count;
  logic                        room, adv, take, pop;

  // scan datapath
  logic                         is_prefix, do_idle, num_step;
  logic [4:0]                   hexv;
  logic                         dig_ok;
  logic [ats_pkg::VALUE_W+3:0]  prod;
  logic [11:0]                  reg_val;
  logic                         va, vb, vc;
  ats_pkg::tok_t                ta, tb, tc;
  logic [1:0]                   push_n;
  logic [ats_pkg::QPTR_W-1:0]   idx_a, idx_b, idx_c;

  assign room     = q_count <= ats_pkg::QCNT_W'(ats_pkg::QDEPTH - ats_pkg::MAX_RUN);
  assign adv      = s_valid && room;
  assign in_stall = s_valid && !room;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_line   <= ats_pkg::LINE_W'(1);
      start_column <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ats_pkg::CFG_START_LINE:   start_line   <= cfg_data;
        ats_pkg::CFG_START_COLUMN: start_column <= cfg_data[ats_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_char <= char_code;
      s_last <= is_last;
    end
  end

  // one byte through the scanner
  always_comb begin
    mode_next     = mode;
    radix_next    = radix;
    skip_next     = skip;
    accum_next    = accum;
    good_next     = good;
    seen_next     = seen;
    wbytes_next   = wbytes;
    wlen_next     = wlen;
    ridx_next     = ridx;
    rgood_next    = rgood;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    first_next    = first;
    bline_next    = bline;
    bcol_next     = bcol;
    va = 1'b0;
    vb = 1'b0;
    vc = 1'b0;
    ta = '0;
    tb = '0;
    tc = '0;
    do_idle  = 1'b0;
    num_step = 1'b0;
    prod     = '0;
    reg_val  = '0;
    dig_ok   = 1'b0;
    hexv     = ats_pkg::hex_val(s_char);
    is_prefix = (mode == ats_pkg::MODE_PEND) &&
                ((s_char == ats_pkg::CH_LOW_B) || (s_char == ats_pkg::CH_LOW_O) ||
                 (s_char == ats_pkg::CH_LOW_X));

    // position of this byte
    if (first) begin
      line_cnt_next = start_line;
      col_cnt_next  = start_column;
      first_next    = 1'b0;
    end else if (skip) begin
      skip_next = 1'b0;
    end else if (!is_prefix) begin
      if (s_char == ats_pkg::CH_LF) begin
        if (line_cnt != ats_pkg::LINE_MAX) line_cnt_next = line_cnt + 1'b1;
        col_cnt_next = '0;
      end else if (col_cnt != ats_pkg::COL_MAX) begin
        col_cnt_next = col_cnt + 1'b1;
      end
    end

    // mode handling
    unique case (mode)
      ats_pkg::MODE_COMMENT: begin
        if (s_char == ats_pkg::CH_LF) mode_next = ats_pkg::MODE_IDLE;
      end
      ats_pkg::MODE_PEND, ats_pkg::MODE_NUM: begin
        if (is_prefix) begin
          unique case (s_char)
            ats_pkg::CH_LOW_B: radix_next = ats_pkg::RADIX_BIN;
            ats_pkg::CH_LOW_O: radix_next = ats_pkg::RADIX_OCT;
            default:           radix_next = ats_pkg::RADIX_HEX;
          endcase
          accum_next = '0;
          seen_next  = 1'b0;
          mode_next  = ats_pkg::MODE_NUM;
          skip_next  = 1'b1;
        end else if (hexv != 5'd16) begin
          num_step  = 1'b1;
          mode_next = ats_pkg::MODE_NUM;
        end else begin
          va = 1'b1;
          ta = ats_pkg::make_number(good, seen || (mode == ats_pkg::MODE_PEND), accum,
                                    bline, bcol);
          do_idle = 1'b1;
        end
      end
      ats_pkg::MODE_WORD: begin
        if (ats_pkg::is_word(s_char)) begin
          // append byte, track register index
          for (int k = 0; k < 8; k++) begin
            if (wlen == ats_pkg::LEN_W'(k)) wbytes_next[8*k +: 8] = s_char;
          end
          if (rgood) begin
            if (ats_pkg::is_digit(s_char)) begin
              reg_val = {1'b0, ridx, 3'b000} + {3'b000, ridx, 1'b0} + {8'd0, s_char[3:0]};
              if (reg_val >= 12'(ats_pkg::REGISTER_COUNT)) rgood_next = 1'b0;
              else ridx_next = reg_val[7:0];
            end else begin
              rgood_next = 1'b0;
            end
          end
          if (wlen != ats_pkg::LEN_MAX) wlen_next = wlen + 1'b1;
        end else begin
          va = 1'b1;
          ta = ats_pkg::make_word(rgood, ridx, wlen, wbytes, bline, bcol);
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // digit appended to a number
    if (num_step) begin
      dig_ok = good && (hexv < ats_pkg::radix_base(radix));
      unique case (radix)
        ats_pkg::RADIX_DEC: prod = {accum, 3'b000} + {2'b00, accum, 1'b0} + 68'(hexv);
        ats_pkg::RADIX_BIN: prod = {3'b000, accum, 1'b0} + 68'(hexv);
        ats_pkg::RADIX_OCT: prod = {1'b0, accum, 3'b000} + 68'(hexv);
        default:            prod = {accum, 4'b0000} + 68'(hexv);
      endcase
      if (dig_ok && (prod[ats_pkg::VALUE_W+3:ats_pkg::VALUE_W] != 4'd0)) begin
        dig_ok = 1'b0;
      end else if (dig_ok) begin
        accum_next = prod[ats_pkg::VALUE_W-1:0];
      end
      good_next = dig_ok;
      seen_next = 1'b1;
    end

    // byte seen between tokens
    if (do_idle) begin
      mode_next = ats_pkg::MODE_IDLE;
      if (ats_pkg::is_space(s_char)) begin
        mode_next = ats_pkg::MODE_IDLE;
      end else if (s_char == ats_pkg::CH_SEMI) begin
        mode_next = ats_pkg::MODE_COMMENT;
      end else begin
        bline_next = line_cnt_next;
        bcol_next  = col_cnt_next;
        if (ats_pkg::is_digit(s_char)) begin
          mode_next  = ats_pkg::MODE_PEND;
          radix_next = ats_pkg::RADIX_DEC;
          accum_next = {60'd0, s_char[3:0]};
          good_next  = 1'b1;
          seen_next  = 1'b0;
        end else if (ats_pkg::is_alpha(s_char) || (s_char == ats_pkg::CH_UNDER)) begin
          mode_next   = ats_pkg::MODE_WORD;
          wbytes_next = {56'd0, s_char};
          wlen_next   = ats_pkg::LEN_W'(1);
          ridx_next   = '0;
          rgood_next  = (s_char == ats_pkg::CH_LOW_R);
        end else if (s_char == ats_pkg::CH_COLON) begin
          vb = 1'b1;
          tb = ats_pkg::make_simple(ats_pkg::TK_COLON, line_cnt_next, col_cnt_next);
        end else if (s_char == ats_pkg::CH_COMMA) begin
          vb = 1'b1;
          tb = ats_pkg::make_simple(ats_pkg::TK_COMMA, line_cnt_next, col_cnt_next);
        end else begin
          vb = 1'b1;
          tb = ats_pkg::make_simple(ats_pkg::TK_UNKNOWN, line_cnt_next, col_cnt_next);
        end
      end
    end

    // end of content: close the open token, add eof, restart
    if (s_last) begin
      unique case (mode_next)
        ats_pkg::MODE_PEND: begin
          vb = 1'b1;
          tb = ats_pkg::make_number(good_next, 1'b1, accum_next, bline_next, bcol_next);
        end
        ats_pkg::MODE_NUM: begin
          vb = 1'b1;
          tb = ats_pkg::make_number(good_next, seen_next, accum_next, bline_next, bcol_next);
        end
        ats_pkg::MODE_WORD: begin
          vb = 1'b1;
          tb = ats_pkg::make_word(rgood_next, ridx_next, wlen_next, wbytes_next,
                                  bline_next, bcol_next);
        end
        default: ;
      endcase
      vc = 1'b1;
      tc = ats_pkg::make_simple(ats_pkg::TK_EOF, line_cnt_next, col_cnt_next);
      mode_next   = ats_pkg::MODE_IDLE;
      radix_next  = ats_pkg::RADIX_DEC;
      skip_next   = 1'b0;
      accum_next  = '0;
      good_next   = 1'b1;
      seen_next   = 1'b0;
      wbytes_next = '0;
      wlen_next   = '0;
      ridx_next   = '0;
      rgood_next  = 1'b0;
      first_next  = 1'b1;
      bline_next  = '0;
      bcol_next   = '0;
    end

    ta.last = !vb && !vc;
    tb.last = !vc;
    tc.last = 1'b1;
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ats_pkg::MODE_IDLE;
      radix    <= ats_pkg::RADIX_DEC;
      skip     <= 1'b0;
      accum    <= '0;
      good     <= 1'b1;
      seen     <= 1'b0;
      wbytes   <= '0;
      wlen     <= '0;
      ridx     <= '0;
      rgood    <= 1'b0;
      line_cnt <= ats_pkg::LINE_W'(1);
      col_cnt  <= '0;
      first    <= 1'b1;
      bline    <= '0;
      bcol     <= '0;
    end else if (adv) begin
      mode     <= mode_next;
      radix    <= radix_next;
      skip     <= skip_next;
      accum    <= accum_next;
      good     <= good_next;
      seen     <= seen_next;
      wbytes   <= wbytes_next;
      wlen     <= wlen_next;
      ridx     <= ridx_next;
      rgood    <= rgood_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
      first    <= first_next;
      bline    <= bline_next;
      bcol     <= bcol_next;
    end
  end

  // queue write positions: tokens packed in order
  assign push_n = adv ? (2'(va) + 2'(vb) + 2'(vc)) : 2'd0;
  assign idx_a  = wr_ptr;
  assign idx_b  = wr_ptr + ats_pkg::QPTR_W'(va);
  assign idx_c  = wr_ptr + ats_pkg::QPTR_W'(va) + ats_pkg::QPTR_W'(vb);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < ats_pkg::QDEPTH; i++) begin
        if (va && (idx_a == ats_pkg::QPTR_W'(i))) q[i] <= ta;
        if (vb && (idx_b == ats_pkg::QPTR_W'(i))) q[i] <= tb;
        if (vc && (idx_c == ats_pkg::QPTR_W'(i))) q[i] <= tc;
      end
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + ats_pkg::QPTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      q_count <= q_count + ats_pkg::QCNT_W'(push_n) - ats_pkg::QCNT_W'(pop);
    end
  end

  // output side
  always_comb begin
    out_valid    = q_count != '0;
    token_kind   = q[rd_ptr].kind;
    token_line   = q[rd_ptr].line;
    token_column = q[rd_ptr].column;
    token_value  = q[rd_ptr].value;
    text_length  = q[rd_ptr].length;
    last_of_run  = q[rd_ptr].last;
  end

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ats_pkg::QCNT_W'(ats_pkg::QDEPTH))
    else $error("result queue overfilled");

  // three tokens from one byte only when it ends the content
  a_three_needs_last: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd3) |-> s_last)
    else $error("three tokens from a byte that is not last");

  // a last byte restarts position tracking
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (adv && s_last) |=> (first && (mode == ats_pkg::MODE_IDLE)))
    else $error("scanner did not restart after last byte");

  // pending position skip only inside a prefixed number
  a_skip_in_number: assert property (@(posedge clk) disable iff (rst)
    skip |-> ((mode == ats_pkg::MODE_NUM) && (radix != ats_pkg::RADIX_DEC)))
    else $error("position skip outside a prefixed number");

endmodule

`default_nettype wire

/* dv/assembly_token_scanner_tb.sv */
`timescale 1ns / 1ps

module assembly_token_scanner_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 30;
  localparam int PHASE_COUNT    = 5;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_VTAB   = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } src_item_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic                         cfg_index = 1'b0;
  logic [ats_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [7:0]                   char_code = '0;
  logic                         is_last = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [2:0]                   token_kind;
  logic [ats_pkg::LINE_W-1:0]   token_line;
  logic [ats_pkg::COL_W-1:0]    token_column;
  logic [ats_pkg::VALUE_W-1:0]  token_value;
  logic [ats_pkg::LEN_W-1:0]    text_length;
  logic                         last_of_run;

  assembly_token_scanner i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_line   (token_line),
    .token_column (token_column),
    .token_value  (token_value),
    .text_length  (text_length),
    .last_of_run  (last_of_run)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  src_item_t       source_bytes[$];
  ats_pkg::tok_t   tokens_due[$];
  logic [7:0]      draft[$];
  bit              drain_next;
  int              pushed_bytes;
  int              token_errors;
  int              quiet_cycles;

  // scanner shadow state
  logic [ats_pkg::LINE_W-1:0]  first_line;
  logic [ats_pkg::COL_W-1:0]   first_col;
  ats_pkg::scan_mode_t         scan_state;
  ats_pkg::radix_t             radix;
  logic [1:0]                  skip;
  logic [ats_pkg::VALUE_W-1:0] acc;
  logic                        acc_ok;
  logic                        got_digit;
  logic [ats_pkg::VALUE_W-1:0] wbytes;
  logic [ats_pkg::LEN_W-1:0]   wlen;
  logic [7:0]                  ridx;
  logic                        rok;
  logic [ats_pkg::LINE_W-1:0]  cur_line;
  logic [ats_pkg::COL_W-1:0]   cur_col;
  logic                        fresh;
  logic [ats_pkg::LINE_W-1:0]  tok_line;
  logic [ats_pkg::COL_W-1:0]   tok_col;
  ats_pkg::tok_t               held;
  bit                          have_held;

  // character classes
  function automatic logic ch_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic ch_letter(logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic ch_blank(logic [7:0] c);
    return (c == ats_pkg::CH_SPACE) || ((c >= ats_pkg::CH_TAB) && (c <= ats_pkg::CH_CR));
  endfunction

  function automatic logic ch_wordy(logic [7:0] c);
    return ch_letter(c) || ch_digit(c) || (c == ats_pkg::CH_UNDER);
  endfunction

  // hex digit weight, 16 for anything else
  function automatic logic [4:0] digit_val(logic [7:0] c);
    if (ch_digit(c)) return 5'(c - CH_0);
    if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) return 5'(c - CH_LOW_A + 8'd10);
    if ((c >= CH_UP_A) && (c <= CH_UP_F)) return 5'(c - CH_UP_A + 8'd10);
    return 5'd16;
  endfunction

  function automatic logic [ats_pkg::VALUE_W-1:0] radix_weight(ats_pkg::radix_t r);
    case (r)
      ats_pkg::RADIX_DEC: return 64'd10;
      ats_pkg::RADIX_BIN: return 64'd2;
      ats_pkg::RADIX_OCT: return 64'd8;
      default:            return 64'd16;
    endcase
  endfunction

  // tokens of one byte are held back by one so the final one gets its flag
  function automatic void post_token(ats_pkg::token_kind_t k,
                                     logic [ats_pkg::LINE_W-1:0] ln,
                                     logic [ats_pkg::COL_W-1:0] col,
                                     logic [ats_pkg::VALUE_W-1:0] val,
                                     logic [ats_pkg::LEN_W-1:0] len);
    if (have_held) tokens_due.push_back(held);
    held.kind   = k;
    held.line   = ln;
    held.column = col;
    held.value  = val;
    held.length = len;
    held.last   = 1'b0;
    have_held   = 1'b1;
  endfunction

  function automatic void finish_run();
    if (have_held) begin
      held.last = 1'b1;
      tokens_due.push_back(held);
      have_held = 1'b0;
    end
  endfunction

  function automatic void clear_scan();
    scan_state = ats_pkg::MODE_IDLE;
    radix      = ats_pkg::RADIX_DEC;
    skip       = '0;
    acc        = '0;
    acc_ok     = 1'b1;
    got_digit  = 1'b0;
    wbytes     = '0;
    wlen       = '0;
    ridx       = '0;
    rok        = 1'b0;
    fresh      = 1'b1;
    tok_line   = '0;
    tok_col    = '0;
  endfunction

  function automatic void model_reset();
    first_line = ats_pkg::LINE_W'(1);
    first_col  = '0;
    clear_scan();
    cur_line  = first_line;
    cur_col   = first_col;
    have_held = 1'b0;
  endfunction

  function automatic void close_number();
    if (acc_ok && got_digit) post_token(ats_pkg::TK_NUMBER, tok_line, tok_col, acc, '0);
    else post_token(ats_pkg::TK_UNKNOWN, tok_line, tok_col, '1, '0);
  endfunction

  function automatic void close_word();
    if (rok && (wlen >= ats_pkg::LEN_W'(2)))
      post_token(ats_pkg::TK_REG, tok_line, tok_col, ats_pkg::VALUE_W'(ridx), '0);
    else if ((wlen == ats_pkg::LEN_W'(3)) && (wbytes == ats_pkg::MOV_PACKED))
      post_token(ats_pkg::TK_KEYWORD, tok_line, tok_col, ats_pkg::KW_MOV,
                 ats_pkg::LEN_W'(3));
    else if ((wlen == ats_pkg::LEN_W'(3)) && (wbytes == ats_pkg::RET_PACKED))
      post_token(ats_pkg::TK_KEYWORD, tok_line, tok_col, ats_pkg::KW_RET,
                 ats_pkg::LEN_W'(3));
    else
      post_token(ats_pkg::TK_IDENT, tok_line, tok_col, wbytes, wlen);
  endfunction

  // accumulate one digit, invalid digit or 64-bit overflow spoils the number
  function automatic void add_digit(logic [7:0] c);
    logic [ats_pkg::VALUE_W-1:0] base;
    logic [ats_pkg::VALUE_W-1:0] d;
    base = radix_weight(radix);
    d    = ats_pkg::VALUE_W'(digit_val(c));
    if (d >= base) acc_ok = 1'b0;
    if (acc_ok) begin
      if (acc > ('1 - d) / base) acc_ok = 1'b0;
      else acc = acc * base + d;
    end
    got_digit = 1'b1;
  endfunction

  function automatic void add_word_byte(logic [7:0] c);
    int v;
    if (wlen < ats_pkg::LEN_W'(8)) wbytes = wbytes | (ats_pkg::VALUE_W'(c) << (8 * wlen));
    if (rok) begin
      if (ch_digit(c)) begin
        v = int'(ridx) * 10 + int'(c) - int'(CH_0);
        if (v >= ats_pkg::REGISTER_COUNT) rok = 1'b0;
        else ridx = 8'(v);
      end else begin
        rok = 1'b0;
      end
    end
    if (wlen != ats_pkg::LEN_MAX) wlen = wlen + 1'b1;
  endfunction

  // byte seen between tokens
  function automatic void open_token(logic [7:0] c);
    if (ch_blank(c)) return;
    if (c == ats_pkg::CH_SEMI) begin
      scan_state = ats_pkg::MODE_COMMENT;
      return;
    end
    tok_line = cur_line;
    tok_col  = cur_col;
    if (ch_digit(c)) begin
      scan_state = ats_pkg::MODE_PEND;
      radix      = ats_pkg::RADIX_DEC;
      acc        = ats_pkg::VALUE_W'(c - CH_0);
      acc_ok     = 1'b1;
      got_digit  = 1'b0;
    end else if (ch_letter(c) || (c == ats_pkg::CH_UNDER)) begin
      scan_state = ats_pkg::MODE_WORD;
      wbytes     = ats_pkg::VALUE_W'(c);
      wlen       = ats_pkg::LEN_W'(1);
      ridx       = '0;
      rok        = (c == ats_pkg::CH_LOW_R);
    end else if (c == ats_pkg::CH_COLON) begin
      post_token(ats_pkg::TK_COLON, cur_line, cur_col, '0, '0);
    end else if (c == ats_pkg::CH_COMMA) begin
      post_token(ats_pkg::TK_COMMA, cur_line, cur_col, '0, '0);
    end else begin
      post_token(ats_pkg::TK_UNKNOWN, cur_line, cur_col, '0, '0);
    end
  endfunction

  // predict the tokens caused by one accepted byte
  function automatic void scan_byte(logic [7:0] c, logic last);
    logic prefix;
    prefix = (scan_state == ats_pkg::MODE_PEND) &&
             ((c == ats_pkg::CH_LOW_B) || (c == ats_pkg::CH_LOW_O) ||
              (c == ats_pkg::CH_LOW_X));

    // position of this byte, prefix byte and the one after it leave it alone
    if (fresh) begin
      cur_line = first_line;
      cur_col  = first_col;
      fresh    = 1'b0;
    end else if (skip != 0) begin
      skip = skip - 1'b1;
    end else if (!prefix) begin
      if (c == ats_pkg::CH_LF) begin
        if (cur_line != ats_pkg::LINE_MAX) cur_line = cur_line + 1'b1;
        cur_col = '0;
      end else if (cur_col != ats_pkg::COL_MAX) begin
        cur_col = cur_col + 1'b1;
      end
    end

    case (scan_state)
      ats_pkg::MODE_COMMENT: begin
        if (c == ats_pkg::CH_LF) scan_state = ats_pkg::MODE_IDLE;
      end
      ats_pkg::MODE_PEND, ats_pkg::MODE_NUM: begin
        if (prefix) begin
          radix = (c == ats_pkg::CH_LOW_B) ? ats_pkg::RADIX_BIN :
                  (c == ats_pkg::CH_LOW_O) ? ats_pkg::RADIX_OCT : ats_pkg::RADIX_HEX;
          acc        = '0;
          got_digit  = 1'b0;
          scan_state = ats_pkg::MODE_NUM;
          skip       = 2'd1;
        end else begin
          if (scan_state == ats_pkg::MODE_PEND) begin
            got_digit  = 1'b1;
            scan_state = ats_pkg::MODE_NUM;
          end
          if (digit_val(c) != 5'd16) begin
            add_digit(c);
          end else begin
            close_number();
            scan_state = ats_pkg::MODE_IDLE;
            open_token(c);
          end
        end
      end
      ats_pkg::MODE_WORD: begin
        if (ch_wordy(c)) begin
          add_word_byte(c);
        end else begin
          close_word();
          scan_state = ats_pkg::MODE_IDLE;
          open_token(c);
        end
      end
      default: begin
        scan_state = ats_pkg::MODE_IDLE;
        open_token(c);
      end
    endcase

    // end of content flushes the open token and adds eof
    if (last) begin
      if (scan_state == ats_pkg::MODE_PEND) begin
        got_digit = 1'b1;
        close_number();
      end else if (scan_state == ats_pkg::MODE_NUM) begin
        close_number();
      end else if (scan_state == ats_pkg::MODE_WORD) begin
        close_word();
      end
      post_token(ats_pkg::TK_EOF, cur_line, cur_col, '0, '0);
      clear_scan();
    end
    finish_run();
  endfunction

  // stimulus building
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  function automatic void flush_content(bit with_last);
    src_item_t it;
    for (int i = 0; i < draft.size(); i++) begin
      it.code  = draft[i];
      it.last  = with_last && (i == draft.size() - 1);
      it.drain = drain_next;
      drain_next = 1'b0;
      source_bytes.push_back(it);
      pushed_bytes++;
    end
    draft.delete();
  endfunction

  function automatic logic [7:0] digit_char(int v);
    if (v < 10) return CH_0 + 8'(v);
    return (($urandom_range(0, 1) == 0) ? CH_LOW_A : CH_UP_A) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return CH_0 + 8'($urandom_range(0, 9));
      1:       return CH_UP_A + 8'($urandom_range(0, 25));
      2:       return ats_pkg::CH_UNDER;
      default: return CH_LOW_A + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] stray_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (ch_wordy(c) || ch_blank(c) || (c == ats_pkg::CH_SEMI) ||
           (c == ats_pkg::CH_COLON) || (c == ats_pkg::CH_COMMA))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic void add_separator();
    case ($urandom_range(0, 5))
      0, 1: ;
      2, 3: draft.push_back(ats_pkg::CH_SPACE);
      4:    draft.push_back(ats_pkg::CH_LF);
      default: begin
        case ($urandom_range(0, 3))
          0:       draft.push_back(ats_pkg::CH_TAB);
          1:       draft.push_back(CH_VTAB);
          2:       draft.push_back(CH_FF);
          default: draft.push_back(ats_pkg::CH_CR);
        endcase
      end
    endcase
  endfunction

  // one well-formed token with random content, or some noise
  function automatic void add_random_token();
    int pick;
    int n;
    int base;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) draft.push_back(CH_0 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) draft.push_back(digit_char($urandom_range(10, 15)));
    end else if (pick < 24) begin
      k = $urandom_range(0, 2);
      base = (k == 0) ? 2 : (k == 1) ? 8 : 16;
      draft.push_back(CH_0 + 8'($urandom_range(0, 9)));
      draft.push_back((k == 0) ? ats_pkg::CH_LOW_B :
                      (k == 1) ? ats_pkg::CH_LOW_O : ats_pkg::CH_LOW_X);
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      repeat (n) draft.push_back(digit_char($urandom_range(0, base - 1)));
      if ($urandom_range(0, 6) == 0) draft.push_back(digit_char($urandom_range(0, 15)));
    end else if (pick < 28) begin
      case ($urandom_range(0, 4))
        0:       add_text("18446744073709551615");
        1:       add_text("18446744073709551616");
        2:       add_text("0xFFFFFFFFFFFFFFFF");
        3:       add_text("0x10000000000000000");
        default: add_text("99999999999999999999");
      endcase
    end else if (pick < 40) begin
      case ($urandom_range(0, 5))
        0:       add_text("r");
        1:       add_text($sformatf("r0%0d", $urandom_range(0, 40)));
        2:       add_text($sformatf("R%0d", $urandom_range(0, 40)));
        default: add_text($sformatf("r%0d", $urandom_range(0, 40)));
      endcase
    end else if (pick < 48) begin
      case ($urandom_range(0, 7))
        0:       add_text("MOV");
        1:       add_text("rett");
        2:       add_text("mo");
        3, 4:    add_text("ret");
        default: add_text("mov");
      endcase
    end else if (pick < 62) begin
      draft.push_back(($urandom_range(0, 5) == 0) ? ats_pkg::CH_UNDER :
                      CH_LOW_A + 8'($urandom_range(0, 25)));
      n = $urandom_range(0, 11);
      repeat (n) draft.push_back(word_char());
    end else if (pick < 68) begin
      draft.push_back(ats_pkg::CH_COLON);
    end else if (pick < 74) begin
      draft.push_back(ats_pkg::CH_COMMA);
    end else if (pick < 80) begin
      draft.push_back(stray_byte());
    end else if (pick < 88) begin
      draft.push_back(ats_pkg::CH_SEMI);
      n = $urandom_range(0, 6);
      repeat (n) begin
        k = $urandom_range(0, 255);
        draft.push_back((8'(k) == ats_pkg::CH_LF) ? ats_pkg::CH_SPACE : 8'(k));
      end
      draft.push_back(ats_pkg::CH_LF);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) draft.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // configuration write, idle only
  task automatic set_start(logic idx, logic [ats_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ats_pkg::CFG_START_LINE) first_line = data;
    else first_col = data[ats_pkg::COL_W-1:0];
  endtask

  task automatic wait_idle();
    while (source_bytes.size() != 0 || in_valid || tokens_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // request driver: bursts of random length with random gaps
  src_item_t next_item;
  int        gap_left;
  int        burst_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      char_code  <= '0;
      is_last    <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (in_fire) scan_byte(char_code, is_last);
      if (in_valid && !in_fire) begin
        // held until accepted
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (source_bytes.size() != 0 &&
                   !(source_bytes[0].drain && tokens_due.size() != 0)) begin
        next_item = source_bytes.pop_front();
        in_valid  <= 1'b1;
        char_code <= next_item.code;
        is_last   <= next_item.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // token monitor and receiver stall pattern
  ats_pkg::tok_t got;
  ats_pkg::tok_t want;
  int            stall_mode;
  int            stall_left;
  int            stall_run;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
      stall_run  = 0;
    end else begin
      if (out_fire) begin
        got.kind   = ats_pkg::token_kind_t'(token_kind);
        got.line   = token_line;
        got.column = token_column;
        got.value  = token_value;
        got.length = text_length;
        got.last   = last_of_run;
        if (tokens_due.size() == 0) begin
          if (token_errors < 10)
            $display("unexpected token: kind %0d line %0d col %0d value %h len %0d last %0b",
                     got.kind, got.line, got.column, got.value, got.length, got.last);
          token_errors++;
        end else begin
          want = tokens_due.pop_front();
          if (got.kind !== want.kind || got.line !== want.line ||
              got.column !== want.column || got.value !== want.value ||
              got.length !== want.length || got.last !== want.last) begin
            if (token_errors < 10) begin
              $display("token mismatch at %0t", $realtime);
              $display("  expected kind %0d line %0d col %0d value %h len %0d last %0b",
                       want.kind, want.line, want.column, want.value, want.length,
                       want.last);
              $display("  actual   kind %0d line %0d col %0d value %h len %0d last %0b",
                       got.kind, got.line, got.column, got.value, got.length, got.last);
            end
            token_errors++;
          end
        end
      end

      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 150);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          // long stalls alternating with short open windows
          if (stall_run == 0) begin
            out_stall <= !out_stall;
            stall_run = out_stall ? $urandom_range(1, 8) : $urandom_range(1, 30);
          end else begin
            stall_run--;
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || in_fire || out_fire || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // stimulus and end of run
  int phase_goal;

  initial begin
    model_reset();
    drain_next   = 1'b0;
    pushed_bytes = 0;
    token_errors = 0;
    quiet_cycles = 0;

    // directed: every kind, prefix, comment, extreme bytes, three tokens from one byte
    add_text("mov r31,0x1F:ret;c\n_");
    draft.push_back(8'hff);
    draft.push_back(8'h00);
    add_text(" 9a,");
    flush_content(1'b1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      case (p)
        0: begin
          set_start(ats_pkg::CFG_START_LINE, '0);
          set_start(ats_pkg::CFG_START_COLUMN, '0);
        end
        1: begin
          set_start(ats_pkg::CFG_START_LINE, 24'hffffff);
          set_start(ats_pkg::CFG_START_COLUMN, 24'hffffff);
        end
        2: begin
          set_start(ats_pkg::CFG_START_LINE, 24'hfffffe);
          set_start(ats_pkg::CFG_START_COLUMN, 24'h00fffe);
          drain_next = 1'b1;
        end
        3: begin
          set_start(ats_pkg::CFG_START_LINE,
                    ats_pkg::CFG_W'($urandom_range(0, 24'hffffff)));
          set_start(ats_pkg::CFG_START_COLUMN,
                    ats_pkg::CFG_W'($urandom_range(0, 24'hffffff)));
        end
        default: set_start(ats_pkg::CFG_START_LINE,
                           ats_pkg::CFG_W'($urandom_range(0, 24'hffffff)));
      endcase

      @(negedge clk);
      phase_goal = pushed_bytes + PHASE_BYTES;
      while (pushed_bytes < phase_goal) begin
        repeat ($urandom_range(1, 12)) begin
          add_random_token();
          add_separator();
        end
        if ($urandom_range(0, 11) == 0) drain_next = 1'b1;
        flush_content(1'b1);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (token_errors == 0 && tokens_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
